FILE: rtl/core/brf_pkg.sv
// shared types, codes and reset values for the byte ring fifo
package brf_pkg;

   // default geometry
   localparam int DEPTH_DEFAULT     = 1024;
   localparam int MAX_BURST_DEFAULT = 64;

   // fixed field widths
   localparam int LEVEL_W = 11;
   localparam int LEN_W   = 7;
   localparam int TIME_W  = 32;
   localparam int CSR_IDX_W = 2;

   // register reset values
   localparam logic [LEVEL_W-1:0] THRESHOLD_RESET = 11'd512;
   localparam logic [LEVEL_W-1:0] FRAME_RESET     = 11'd16;
   localparam logic [TIME_W-1:0]  TIMEOUT_RESET   = 32'd100;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT   = 2'd2;

   // operation codes
   typedef enum logic [2:0] {
      MODE_WRITE  = 3'd0,
      MODE_FRAME  = 3'd1,
      MODE_READ   = 3'd2,
      MODE_PEEK   = 3'd3,
      MODE_COMMIT = 3'd4,
      MODE_MARK   = 3'd5
   } brf_mode_type;

   // sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_STATUS,
      ST_BURST
   } brf_state_type;

   // request item
   typedef struct packed {
      logic [2:0]        mode;
      logic [7:0]        data_byte;
      logic              frame_start;
      logic [LEN_W-1:0]  length;
      logic [TIME_W-1:0] tick_time;
   } brf_req_type;

   // result item
   typedef struct packed {
      logic [7:0]         out_byte;
      logic               byte_valid;
      logic               accepted;
      logic [LEN_W-1:0]   done_count;
      logic [LEVEL_W-1:0] fill_level;
      logic               notify;
      logic               last;
   } brf_rsp_type;

   // configuration register set
   typedef struct packed {
      logic [LEVEL_W-1:0] notify_threshold;
      logic [LEVEL_W-1:0] frame_bytes;
      logic [TIME_W-1:0]  notify_timeout;
   } brf_cfg_type;

endpackage

FILE: rtl/core/brf_ram.sv
// byte store: one write port, one registered read port
module brf_ram #(
   parameter int DEPTH = brf_pkg::DEPTH_DEFAULT,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [7:0]    wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [7:0]    rd_data
);
   import brf_pkg::*;

   logic [7:0] store_mem [DEPTH];
   logic [7:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= store_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/brf_notify.sv
// notify decision from fill level, frame size and elapsed wrapping time
module brf_notify #(
   parameter int DEPTH = brf_pkg::DEPTH_DEFAULT,
   parameter int CW    = $clog2(DEPTH + 1)
) (
   input  logic [CW-1:0]                    fill_count,
   input  brf_pkg::brf_cfg_type             cfg,
   input  logic [brf_pkg::TIME_W-1:0]       last_time,
   input  logic [brf_pkg::TIME_W-1:0]       now_time,
   output logic                             notify
);
   import brf_pkg::*;

   localparam int CMPW = (CW > LEVEL_W) ? CW : LEVEL_W;

   logic [CMPW-1:0]   count_w;
   logic [TIME_W-1:0] elapsed;
   logic              over_threshold;
   logic              frame_present;
   logic              timed_out;

   // compare unit, evaluated on the cycle a result is shown
   always_comb begin
      count_w        = CMPW'(fill_count);
      elapsed        = now_time - last_time;
      over_threshold = count_w >= CMPW'(cfg.notify_threshold);
      frame_present  = count_w >= CMPW'(cfg.frame_bytes);
      timed_out      = elapsed >= cfg.notify_timeout;
      notify         = over_threshold || (frame_present && timed_out);
   end

endmodule

FILE: rtl/core/brf_seq.sv
// operation sequencer: pointers, fill count, frame admission and byte bursts
module brf_seq #(
   parameter int DEPTH     = brf_pkg::DEPTH_DEFAULT,
   parameter int MAX_BURST = brf_pkg::MAX_BURST_DEFAULT,
   parameter int AW        = $clog2(DEPTH),
   parameter int CW        = $clog2(DEPTH + 1)
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  brf_pkg::brf_req_type        req_payload,
   input  brf_pkg::brf_cfg_type        cfg,
   output logic                        rsp_valid,
   output brf_pkg::brf_rsp_type        rsp_payload,
   input  logic                        notify,
   output logic [CW-1:0]               fill_count,
   output logic [brf_pkg::TIME_W-1:0]  last_time,
   output logic [brf_pkg::TIME_W-1:0]  now_time,
   output logic                        ram_wr_en,
   output logic [AW-1:0]               ram_wr_addr,
   output logic [7:0]                  ram_wr_data,
   output logic                        ram_rd_en,
   output logic [AW-1:0]               ram_rd_addr,
   input  logic [7:0]                  ram_rd_data
);
   import brf_pkg::*;

   localparam int CMPW = (CW > LEVEL_W) ? CW : LEVEL_W;
   localparam int MW   = (CW > LEN_W) ? CW : LEN_W;

   brf_state_type     state_ff, state_in;
   brf_req_type       item_ff, item_in;
   logic [AW-1:0]     wr_idx_ff, wr_idx_in;
   logic [AW-1:0]     rd_idx_ff, rd_idx_in;
   logic [AW-1:0]     pos_ff, pos_in;
   logic [CW-1:0]     count_ff, count_in;
   logic              admit_ff, admit_in;
   logic [TIME_W-1:0] last_time_ff, last_time_in;
   logic [LEN_W-1:0]  total_ff, total_in;
   logic [LEN_W-1:0]  sent_ff, sent_in;
   logic              acc_ff, acc_in;
   logic [LEN_W-1:0]  done_ff, done_in;

   logic              full;
   logic [CW-1:0]     free_slots;
   logic              room_for_frame;
   logic [MW-1:0]     avail;
   logic [MW-1:0]     burst_n;
   logic [CW:0]       commit_sum;
   logic [LEN_W-1:0]  sent_next;
   logic              is_read;

   // ring index advance
   function automatic logic [AW-1:0] inc_idx(input logic [AW-1:0] idx);
      inc_idx = (idx == AW'(DEPTH - 1)) ? '0 : idx + AW'(1);
   endfunction

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wr_idx_ff    <= '0;
         rd_idx_ff    <= '0;
         count_ff     <= '0;
         admit_ff     <= 1'b0;
         last_time_ff <= '0;
      end else begin
         state_ff     <= state_in;
         wr_idx_ff    <= wr_idx_in;
         rd_idx_ff    <= rd_idx_in;
         count_ff     <= count_in;
         admit_ff     <= admit_in;
         last_time_ff <= last_time_in;
      end
   end

   // item and burst bookkeeping
   always_ff @(posedge clock) begin
      item_ff  <= item_in;
      pos_ff   <= pos_in;
      total_ff <= total_in;
      sent_ff  <= sent_in;
      acc_ff   <= acc_in;
      done_ff  <= done_in;
   end

   // shared compares and sums on the held item
   always_comb begin
      full           = count_ff == CW'(DEPTH);
      free_slots     = CW'(DEPTH) - count_ff;
      room_for_frame = CMPW'(cfg.frame_bytes) <= CMPW'(free_slots);
      avail          = (MW'(item_ff.length) < MW'(count_ff)) ? MW'(item_ff.length)
                                                              : MW'(count_ff);
      burst_n        = (avail > MW'(MAX_BURST)) ? MW'(MAX_BURST) : avail;
      commit_sum     = (CW + 1)'(rd_idx_ff) + (CW + 1)'(CW'(avail));
      if (commit_sum >= (CW + 1)'(DEPTH)) begin
         commit_sum = commit_sum - (CW + 1)'(DEPTH);
      end
      sent_next      = sent_ff + LEN_W'(1);
      is_read        = item_ff.mode == MODE_READ;
   end

   // next state and outputs
   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      wr_idx_in    = wr_idx_ff;
      rd_idx_in    = rd_idx_ff;
      pos_in       = pos_ff;
      count_in     = count_ff;
      admit_in     = admit_ff;
      last_time_in = last_time_ff;
      total_in     = total_ff;
      sent_in      = sent_ff;
      acc_in       = acc_ff;
      done_in      = done_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = wr_idx_ff;
      ram_wr_data  = item_ff.data_byte;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = pos_ff;
      rsp_valid    = 1'b0;
      rsp_payload  = '0;
      rsp_payload.fill_level = LEVEL_W'(count_ff);
      rsp_payload.notify     = notify;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               item_in  = req_payload;
               state_in = ST_EXEC;
            end
         end

         ST_EXEC: begin
            acc_in   = 1'b0;
            done_in  = '0;
            state_in = ST_STATUS;
            case (item_ff.mode)
               MODE_WRITE: begin
                  if (!full) begin
                     ram_wr_en = 1'b1;
                     wr_idx_in = inc_idx(wr_idx_ff);
                     count_in  = count_ff + CW'(1);
                     acc_in    = 1'b1;
                  end
               end
               MODE_FRAME: begin
                  // frame start re-decides admission for the whole frame
                  if ((item_ff.frame_start ? room_for_frame : admit_ff) && !full) begin
                     ram_wr_en = 1'b1;
                     wr_idx_in = inc_idx(wr_idx_ff);
                     count_in  = count_ff + CW'(1);
                     acc_in    = 1'b1;
                  end
                  if (item_ff.frame_start) begin
                     admit_in = room_for_frame;
                  end
               end
               MODE_READ, MODE_PEEK: begin
                  if (burst_n != '0) begin
                     ram_rd_en   = 1'b1;
                     ram_rd_addr = rd_idx_ff;
                     pos_in      = inc_idx(rd_idx_ff);
                     total_in    = LEN_W'(burst_n);
                     sent_in     = '0;
                     state_in    = ST_BURST;
                     if (is_read) begin
                        rd_idx_in = inc_idx(rd_idx_ff);
                        count_in  = count_ff - CW'(1);
                     end
                  end
               end
               MODE_COMMIT: begin
                  rd_idx_in = AW'(commit_sum);
                  count_in  = count_ff - CW'(avail);
                  done_in   = LEN_W'(avail);
               end
               MODE_MARK: begin
                  last_time_in = item_ff.tick_time;
               end
               default: begin
               end
            endcase
         end

         ST_STATUS: begin
            rsp_valid              = 1'b1;
            rsp_payload.accepted   = acc_ff;
            rsp_payload.done_count = done_ff;
            rsp_payload.last       = 1'b1;
            state_in               = ST_IDLE;
         end

         ST_BURST: begin
            rsp_valid              = 1'b1;
            rsp_payload.out_byte   = ram_rd_data;
            rsp_payload.byte_valid = 1'b1;
            rsp_payload.done_count = sent_next;
            rsp_payload.last       = sent_next == total_ff;
            sent_in                = sent_next;
            // fetch the following byte while this one is shown
            if (sent_next == total_ff) begin
               state_in = ST_IDLE;
            end else begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = pos_ff;
               pos_in      = inc_idx(pos_ff);
               if (is_read) begin
                  rd_idx_in = inc_idx(pos_ff);
                  count_in  = count_ff - CW'(1);
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy       = state_ff != ST_IDLE;
   assign fill_count = count_ff;
   assign last_time  = last_time_ff;
   assign now_time   = item_ff.tick_time;

endmodule

FILE: rtl/core/byte_ring_fifo_with_notify.sv
// top level of the byte ring fifo with notify
// Byte ring buffer of DEPTH bytes driven by start/busy commands, one operation per
// command. Write, frame byte, commit/drop, mark notified and unused codes pass through
// accept (idle), execute and status from one accepted command to the next and give
// one result in the status state. A read or peek of n bytes (n limited by the fill
// level and MAX_BURST) shows its first byte in the burst state that follows execute and
// then one byte every cycle, holding busy through execute and all n bytes; the single
// read port of the byte store sets that pace. Results are strobed for one cycle on
// rsp_valid and cannot be held off, so a receiver must take one every cycle. The byte
// store has no reset and needs no clearing pass: only held bytes are ever read.
// Configuration writes complete at once and must be made while busy is low.
module byte_ring_fifo_with_notify #(
   parameter int DEPTH     = brf_pkg::DEPTH_DEFAULT,
   parameter int MAX_BURST = brf_pkg::MAX_BURST_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  brf_pkg::brf_req_type            req_payload,
   output logic                            rsp_valid,
   output brf_pkg::brf_rsp_type            rsp_payload,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [brf_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [brf_pkg::TIME_W-1:0]      csr_data
);
   import brf_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   logic [LEVEL_W-1:0] threshold_ff;
   logic [LEVEL_W-1:0] frame_ff;
   logic [TIME_W-1:0]  timeout_ff;
   brf_cfg_type        cfg;

   logic               notify;
   logic [CW-1:0]      fill_count;
   logic [TIME_W-1:0]  last_time;
   logic [TIME_W-1:0]  now_time;
   logic               ram_wr_en;
   logic [AW-1:0]      ram_wr_addr;
   logic [7:0]         ram_wr_data;
   logic               ram_rd_en;
   logic [AW-1:0]      ram_rd_addr;
   logic [7:0]         ram_rd_data;

   // configuration registers, one transfer per cycle
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THRESHOLD_RESET;
         frame_ff     <= FRAME_RESET;
         timeout_ff   <= TIMEOUT_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_THRESHOLD: threshold_ff <= csr_data[LEVEL_W-1:0];
            CSR_FRAME:     frame_ff     <= csr_data[LEVEL_W-1:0];
            CSR_TIMEOUT:   timeout_ff   <= csr_data;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      cfg.notify_threshold = threshold_ff;
      cfg.frame_bytes      = frame_ff;
      cfg.notify_timeout   = timeout_ff;
   end

   // sequencer
   brf_seq #(
      .DEPTH     (DEPTH),
      .MAX_BURST (MAX_BURST),
      .AW        (AW),
      .CW        (CW)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .cfg         (cfg),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload),
      .notify      (notify),
      .fill_count  (fill_count),
      .last_time   (last_time),
      .now_time    (now_time),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_en   (ram_rd_en),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data)
   );

   // notify compare unit
   brf_notify #(
      .DEPTH (DEPTH),
      .CW    (CW)
   ) u_notify (
      .fill_count (fill_count),
      .cfg        (cfg),
      .last_time  (last_time),
      .now_time   (now_time),
      .notify     (notify)
   );

   // byte store
   brf_ram #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

endmodule

FILE: rtl/core/brf_checker.sv
// port-level checks for the byte ring fifo, bound to the top level
module brf_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 start,
   input logic                 busy,
   input logic                 rsp_valid,
   input brf_pkg::brf_rsp_type rsp_payload
);
   import brf_pkg::*;

   // results only while a command is in flight
   a_rsp_while_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result shown while idle");

   // the cycle after a command transfer is execution, with no result
   a_exec_after_accept: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy && !rsp_valid))
      else $error("no execute cycle after command transfer");

   // the final result frees the block
   a_idle_after_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.last) |=> (!rsp_valid && !busy))
      else $error("block still busy after final result");

   // a burst continues with a data byte every cycle
   a_burst_continues: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_payload.last) |=> (rsp_valid && rsp_payload.byte_valid))
      else $error("burst broken before final byte");

   // a status-only result is always the single result of its command
   a_status_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_payload.byte_valid) |-> rsp_payload.last)
      else $error("status result not marked last");

endmodule

bind byte_ring_fifo_with_notify brf_checker u_brf_checker (
   .clock       (clock),
   .reset       (reset),
   .start       (start),
   .busy        (busy),
   .rsp_valid   (rsp_valid),
   .rsp_payload (rsp_payload)
);

FILE: bench/testbench.sv
// self-checking testbench for the byte ring fifo with notify
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import brf_pkg::*;

   localparam int RING_DEPTH   = DEPTH_DEFAULT;
   localparam int BURST_MAX    = MAX_BURST_DEFAULT;
   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int DRAIN_CYCLES = 8;

   // codes outside the defined operations, handled as status only
   localparam logic [2:0] MODE_SPARE_A = 3'd6;
   localparam logic [2:0] MODE_SPARE_B = 3'd7;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   logic                 busy;
   brf_req_type          req_payload = '0;
   logic                 rsp_valid;
   brf_rsp_type          rsp_payload;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [TIME_W-1:0]    csr_data = '0;

   // mirror of the ring and its settings
   logic [7:0]          ring_copy [RING_DEPTH];
   int unsigned         wr_ptr = 0;
   int unsigned         rd_ptr = 0;
   int unsigned         held_count = 0;
   bit                  frame_open = 1'b0;
   logic [TIME_W-1:0]   notified_at = '0;
   logic [LEVEL_W-1:0]  cfg_threshold = THRESHOLD_RESET;
   logic [LEVEL_W-1:0]  cfg_frame = FRAME_RESET;
   logic [TIME_W-1:0]   cfg_timeout = TIMEOUT_RESET;

   brf_req_type         pending_cmds [$];
   brf_rsp_type         expected_rsps [$];
   int                  error_count = 0;
   int                  idle_pct = 0;
   logic [TIME_W-1:0]   tick_now = '0;
   int unsigned         cycle_count = 0;

   byte_ring_fifo_with_notify i_dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   // 20 ns clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // notify: fill at threshold, or a frame held and the timeout elapsed (wrapping)
   function automatic bit notify_due(logic [TIME_W-1:0] now);
      logic [TIME_W-1:0] elapsed;
      elapsed = now - notified_at;
      return (held_count >= cfg_threshold) ||
             (held_count >= cfg_frame && elapsed >= cfg_timeout);
   endfunction

   function automatic void push_expected(logic [7:0] data, bit valid, bit acc,
                                         int unsigned done, logic [TIME_W-1:0] now,
                                         bit is_last);
      brf_rsp_type r;
      r.out_byte   = data;
      r.byte_valid = valid;
      r.accepted   = acc;
      r.done_count = LEN_W'(done);
      r.fill_level = LEVEL_W'(held_count);
      r.notify     = notify_due(now);
      r.last       = is_last;
      expected_rsps.push_back(r);
   endfunction

   function automatic bit store_byte(logic [7:0] b);
      if (held_count >= RING_DEPTH) return 1'b0;
      ring_copy[wr_ptr] = b;
      wr_ptr = (wr_ptr + 1) % RING_DEPTH;
      held_count++;
      return 1'b1;
   endfunction

   // expected results of one accepted command
   function automatic void predict_command(brf_req_type cmd);
      bit          acc;
      int unsigned n;
      int unsigned pos;
      case (cmd.mode)
         MODE_WRITE: begin
            acc = store_byte(cmd.data_byte);
            push_expected(8'h00, 1'b0, acc, 0, cmd.tick_time, 1'b1);
         end
         MODE_FRAME: begin
            if (cmd.frame_start)
               frame_open = (cfg_frame <= RING_DEPTH) && (RING_DEPTH - held_count >= cfg_frame);
            acc = 1'b0;
            if (frame_open) acc = store_byte(cmd.data_byte);
            push_expected(8'h00, 1'b0, acc, 0, cmd.tick_time, 1'b1);
         end
         MODE_READ, MODE_PEEK: begin
            n = cmd.length;
            if (n > held_count) n = held_count;
            if (n > BURST_MAX) n = BURST_MAX;
            if (n == 0) begin
               push_expected(8'h00, 1'b0, 1'b0, 0, cmd.tick_time, 1'b1);
            end else begin
               pos = rd_ptr;
               for (int unsigned k = 0; k < n; k++) begin
                  logic [7:0] b;
                  b = ring_copy[pos];
                  pos = (pos + 1) % RING_DEPTH;
                  if (cmd.mode == MODE_READ) begin
                     rd_ptr = pos;
                     held_count--;
                  end
                  push_expected(b, 1'b1, 1'b0, k + 1, cmd.tick_time, k + 1 == n);
               end
            end
         end
         MODE_COMMIT: begin
            n = cmd.length;
            if (n > held_count) n = held_count;
            rd_ptr = (rd_ptr + n) % RING_DEPTH;
            held_count -= n;
            push_expected(8'h00, 1'b0, 1'b0, n, cmd.tick_time, 1'b1);
         end
         MODE_MARK: begin
            notified_at = cmd.tick_time;
            push_expected(8'h00, 1'b0, 1'b0, 0, cmd.tick_time, 1'b1);
         end
         default: begin
            push_expected(8'h00, 1'b0, 1'b0, 0, cmd.tick_time, 1'b1);
         end
      endcase
   endfunction

   // command driver: predicts on each transfer, then offers the next item
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) predict_command(req_payload);
         if (!start || !busy) begin
            if (pending_cmds.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
               start       <= 1'b1;
               req_payload <= pending_cmds.pop_front();
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   function automatic void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endfunction

   // result monitor
   always @(posedge clock) begin : rsp_check
      brf_rsp_type want;
      if (!reset && rsp_valid) begin
         if (expected_rsps.size() == 0) begin
            $error("result transfer with nothing expected, fill %0d", rsp_payload.fill_level);
            error_count++;
         end else begin
            want = expected_rsps.pop_front();
            check_field("out_byte", want.out_byte, rsp_payload.out_byte);
            check_field("byte_valid", want.byte_valid, rsp_payload.byte_valid);
            check_field("accepted", want.accepted, rsp_payload.accepted);
            check_field("done_count", want.done_count, rsp_payload.done_count);
            check_field("fill_level", want.fill_level, rsp_payload.fill_level);
            check_field("notify", want.notify, rsp_payload.notify);
            check_field("last", want.last, rsp_payload.last);
         end
      end
   end

   // register writes seen on the csr port
   always @(posedge clock) begin
      if (!reset && csr_valid && csr_ready) begin
         case (csr_index)
            CSR_THRESHOLD: cfg_threshold = csr_data[LEVEL_W-1:0];
            CSR_FRAME:     cfg_frame = csr_data[LEVEL_W-1:0];
            CSR_TIMEOUT:   cfg_timeout = csr_data;
            default: ;
         endcase
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [TIME_W-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   task automatic configure(logic [LEVEL_W-1:0] threshold, logic [LEVEL_W-1:0] frame,
                            logic [TIME_W-1:0] timeout);
      write_csr(CSR_THRESHOLD, TIME_W'(threshold));
      write_csr(CSR_FRAME, TIME_W'(frame));
      write_csr(CSR_TIMEOUT, timeout);
   endtask

   // wait for all commands and results, then for the tail latency
   task automatic wait_idle();
      do @(posedge clock);
      while (pending_cmds.size() != 0 || start || busy || expected_rsps.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic void add_cmd(logic [2:0] mode, logic [7:0] data, bit fs,
                                   logic [LEN_W-1:0] len, logic [TIME_W-1:0] now);
      brf_req_type c;
      c.mode        = mode;
      c.data_byte   = data;
      c.frame_start = fs;
      c.length      = len;
      c.tick_time   = now;
      pending_cmds.push_back(c);
   endfunction

   // mostly small steps, sometimes a jump anywhere in the 32-bit range
   function automatic logic [TIME_W-1:0] next_tick();
      if ($urandom_range(0, 15) == 0) tick_now = $urandom;
      else tick_now += $urandom_range(0, 40);
      return tick_now;
   endfunction

   function automatic logic [LEN_W-1:0] pick_length();
      return ($urandom_range(0, 9) == 0) ? LEN_W'(127) : LEN_W'($urandom_range(0, 70));
   endfunction

   // random traffic: write runs, whole or cut frames, bursts, commits, marks and noise
   function automatic void add_random_traffic(int budget, int frame_sz);
      int added;
      int pick;
      int run;
      added = 0;
      while (added < budget) begin
         pick = $urandom_range(0, 99);
         if (pick < 25) begin
            run = $urandom_range(1, 12);
            for (int k = 0; k < run; k++)
               add_cmd(MODE_WRITE, 8'($urandom), 1'b0, pick_length(), next_tick());
            added += run;
         end else if (pick < 45) begin
            run = (frame_sz >= 1 && frame_sz <= 20) ? frame_sz : $urandom_range(1, 20);
            if ($urandom_range(0, 4) == 0) run = $urandom_range(1, run);
            for (int k = 0; k < run; k++)
               add_cmd(MODE_FRAME, 8'($urandom), k == 0, pick_length(), next_tick());
            added += run;
         end else if (pick < 60) begin
            add_cmd(MODE_READ, 8'($urandom), 1'($urandom), pick_length(), next_tick());
            added++;
         end else if (pick < 70) begin
            add_cmd(MODE_PEEK, 8'($urandom), 1'($urandom), pick_length(), next_tick());
            added++;
         end else if (pick < 78) begin
            add_cmd(MODE_COMMIT, 8'($urandom), 1'($urandom), pick_length(), next_tick());
            added++;
         end else if (pick < 85) begin
            add_cmd(MODE_MARK, 8'($urandom), 1'($urandom), pick_length(), next_tick());
            added++;
         end else begin
            add_cmd(3'($urandom_range(0, 7)), 8'($urandom), 1'($urandom),
                    LEN_W'($urandom_range(0, 127)), $urandom);
            added++;
         end
      end
   endfunction

   initial begin : stimulus
      int unsigned        k;
      logic [LEVEL_W-1:0] frame_pick;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed part on reset settings
      idle_pct = 0;
      add_cmd(MODE_READ,    8'h00, 1'b0, 7'd5,   32'd0);
      add_cmd(MODE_PEEK,    8'h00, 1'b0, 7'd0,   32'd0);
      add_cmd(MODE_COMMIT,  8'h00, 1'b0, 7'd127, 32'd0);
      add_cmd(MODE_WRITE,   8'h00, 1'b0, 7'd0,   32'd1);
      add_cmd(MODE_WRITE,   8'hFF, 1'b1, 7'd127, 32'd2);
      add_cmd(MODE_WRITE,   8'hA5, 1'b0, 7'd64,  32'd3);
      add_cmd(MODE_PEEK,    8'h00, 1'b0, 7'd127, 32'd4);
      add_cmd(MODE_READ,    8'h00, 1'b0, 7'd2,   32'd5);
      add_cmd(MODE_COMMIT,  8'h00, 1'b0, 7'd127, 32'd6);
      add_cmd(MODE_FRAME,   8'h5A, 1'b1, 7'd0,   32'd7);
      add_cmd(MODE_FRAME,   8'h3C, 1'b0, 7'd0,   32'd8);
      add_cmd(MODE_FRAME,   8'hC3, 1'b0, 7'd0,   32'd9);
      add_cmd(MODE_MARK,    8'h00, 1'b0, 7'd0,   32'hFFFF_FFF0);
      add_cmd(MODE_WRITE,   8'h7F, 1'b0, 7'd0,   32'h0000_0040);
      add_cmd(MODE_WRITE,   8'h80, 1'b0, 7'd0,   32'hFFFF_FFFF);
      add_cmd(MODE_SPARE_A, 8'hFF, 1'b1, 7'd127, 32'h8000_0000);
      add_cmd(MODE_SPARE_B, 8'h00, 1'b0, 7'd3,   32'h0000_0060);
      add_cmd(MODE_READ,    8'h00, 1'b0, 7'd64,  32'h0000_0070);
      add_cmd(MODE_READ,    8'h00, 1'b0, 7'd1,   32'h0000_0080);
      tick_now = 32'h0000_0080;
      wait_idle();

      // notify always on, shortest frame and no timeout
      configure(11'd0, 11'd1, 32'd0);
      idle_pct = 52;
      add_random_traffic(24, 1);
      wait_idle();

      configure(11'd40, 11'd8, 32'd200);
      idle_pct = 24;
      add_random_traffic(24, 8);
      wait_idle();

      // whole-ring frame: admitted on an empty ring, refused once a byte is held
      configure(11'd1024, 11'd1024, 32'hFFFF_FFFF);
      idle_pct = 0;
      for (k = 0; k < held_count; k += 127)
         add_cmd(MODE_COMMIT, 8'h00, 1'b0, 7'd127, next_tick());
      add_cmd(MODE_FRAME, 8'($urandom), 1'b1, 7'd0, next_tick());
      for (k = 1; k < 4; k++)
         add_cmd(MODE_FRAME, 8'($urandom), 1'b0, 7'd0, next_tick());
      add_cmd(MODE_WRITE, 8'($urandom), 1'b0, 7'd0, next_tick());
      add_cmd(MODE_FRAME, 8'($urandom), 1'b1, 7'd0, next_tick());
      add_cmd(MODE_FRAME, 8'($urandom), 1'b0, 7'd0, next_tick());
      add_cmd(MODE_PEEK, 8'h00, 1'b0, 7'd127, next_tick());
      add_cmd(MODE_READ, 8'h00, 1'b0, 7'd64, next_tick());
      add_cmd(MODE_PEEK, 8'h00, 1'b0, 7'd10, next_tick());
      wait_idle();

      // threshold never reached, frame larger than the ring
      configure(11'd2047, 11'd2047, $urandom);
      idle_pct = 52;
      add_random_traffic(24, 2047);
      wait_idle();

      frame_pick = LEVEL_W'($urandom_range(1, 32));
      configure(LEVEL_W'($urandom_range(0, 1024)), frame_pick, $urandom_range(0, 300));
      idle_pct = 24;
      add_random_traffic(24, frame_pick);
      wait_idle();

      frame_pick = LEVEL_W'($urandom_range(1, 20));
      configure(LEVEL_W'($urandom_range(0, 64)), frame_pick, $urandom_range(0, 100));
      idle_pct = 0;
      add_random_traffic(20, frame_pick);
      wait_idle();

      if (expected_rsps.size() != 0) begin
         $error("%0d expected results never arrived", expected_rsps.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
